FILE: rtl/efr_pkg.sv
package efr_pkg;

   // Receive buffer depth; the payload limit never exceeds it
   localparam int BUFFER_DEPTH = 64;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_MAX_PAYLOAD = 1'b0;

   localparam logic [6:0] MAX_PAYLOAD_RESET = 7'd40;

   localparam logic [7:0] CODE_ESC   = 8'hFC;
   localparam logic [7:0] CODE_START = 8'hFE;
   localparam logic [7:0] CODE_END   = 8'hFF;

   localparam logic EVENT_PAYLOAD   = 1'b0;
   localparam logic EVENT_FRAME_END = 1'b1;

   typedef struct packed {
      logic       in_frame;
      logic       escape_pending;
      logic [6:0] byte_count;
   } efr_state_type;

   typedef struct packed {
      logic       event_kind;
      logic [7:0] payload_byte;
      logic [5:0] payload_index;
      logic [6:0] frame_length;
   } efr_result_type;

endpackage

FILE: rtl/efr_req_if.sv
interface efr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/efr_rsp_if.sv
interface efr_rsp_if;
   logic       valid;
   logic       ready;
   logic       event_kind;
   logic [7:0] payload_byte;
   logic [5:0] payload_index;
   logic [6:0] frame_length;

   modport source (output valid, output event_kind, output payload_byte,
                   output payload_index, output frame_length, input ready);
   modport sink   (input valid, input event_kind, input payload_byte,
                   input payload_index, input frame_length, output ready);
endinterface

FILE: rtl/efr_csr.sv
module efr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [efr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [efr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [efr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready,
   output logic [6:0]                    max_payload
);
   import efr_pkg::*;

   logic [6:0] max_payload_ff;
   logic [6:0] max_payload_in;
   logic       reg_sel;

   // register index sits above the byte offset
   assign reg_sel = (paddr[2] == CSR_MAX_PAYLOAD);
   assign pready  = 1'b1;

   always_comb begin
      max_payload_in = max_payload_ff;
      if (psel && penable && pwrite && reg_sel) begin
         max_payload_in = pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_sel) begin
         prdata = {{(CSR_DATA_W-7){1'b0}}, max_payload_ff};
      end
   end

   assign max_payload = max_payload_ff;
endmodule

FILE: rtl/efr_decode.sv
module efr_decode (
   input  logic                   [7:0] rx_byte,
   input  logic                   [6:0] max_payload,
   input  efr_pkg::efr_state_type       state,
   output efr_pkg::efr_state_type       state_next,
   output efr_pkg::efr_result_type      result,
   output logic                         has_result
);
   import efr_pkg::*;

   logic full;
   logic [7:0] data_value;

   // limit is max_payload saturated to the buffer depth
   assign full = ({2'b00, state.byte_count} >= 9'(BUFFER_DEPTH)) ||
                 (state.byte_count >= max_payload);

   assign data_value = state.escape_pending ? (CODE_ESC | {6'b0, rx_byte[1:0]}) : rx_byte;

   always_comb begin
      state_next = state;
      has_result = 1'b0;
      result     = '0;
      if (rx_byte == CODE_START) begin
         state_next.in_frame       = 1'b1;
         state_next.escape_pending = 1'b0;
         state_next.byte_count     = '0;
      end else if (state.in_frame) begin
         if (rx_byte == CODE_ESC) begin
            state_next.escape_pending = 1'b1;
         end else if (rx_byte == CODE_END) begin
            state_next.in_frame       = 1'b0;
            state_next.escape_pending = 1'b0;
            state_next.byte_count     = '0;
            if (state.byte_count != '0) begin
               has_result          = 1'b1;
               result.event_kind   = EVENT_FRAME_END;
               result.frame_length = state.byte_count;
            end
         end else if (full || (state.escape_pending && (rx_byte[7:2] != 6'd0))) begin
            // overlong frame or bad escape: drop, count kept until next start
            state_next.in_frame       = 1'b0;
            state_next.escape_pending = 1'b0;
         end else begin
            has_result                = 1'b1;
            result.event_kind         = EVENT_PAYLOAD;
            result.payload_byte       = data_value;
            result.payload_index      = state.byte_count[5:0];
            state_next.escape_pending = 1'b0;
            state_next.byte_count     = state.byte_count + 7'd1;
         end
      end
   end
endmodule

FILE: rtl/escaped_frame_receiver.sv
// Byte-stuffing deframer. One received byte is taken per clock cycle on the
// req_ channel while req_bus.ready is high, and sustained throughput is one
// byte per cycle while the sink takes every result. Each byte passes an
// input register and then the decode logic into a result register. req_bus.ready
// drops only while the result register holds a transfer that the sink
// refuses; bytes that give no result still pass through the pipeline.
// max_payload (address 0) should be written only while the block is idle.
module escaped_frame_receiver (
   input  logic                           clock,
   input  logic                           reset,
   efr_req_if.sink                        req_bus,
   efr_rsp_if.source                      rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [efr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [efr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [efr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import efr_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           out_valid_ff;
   efr_result_type out_data_ff;
   efr_state_type  state_ff;
   efr_state_type  state_in;
   efr_result_type result;
   logic           has_result;
   logic           advance;
   logic [6:0]     max_payload;

   efr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .max_payload (max_payload)
   );

   efr_decode u_decode (
      .rx_byte     (in_byte_ff),
      .max_payload (max_payload),
      .state       (state_ff),
      .state_next  (state_in),
      .result      (result),
      .has_result  (has_result)
   );

   // result register free, or emptied this cycle
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff && has_result;
            if (in_valid_ff) begin
               state_ff <= state_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.rx_byte;
      end
      if (advance && in_valid_ff && has_result) begin
         out_data_ff <= result;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.event_kind    = out_data_ff.event_kind;
   assign rsp_bus.payload_byte  = out_data_ff.payload_byte;
   assign rsp_bus.payload_index = out_data_ff.payload_index;
   assign rsp_bus.frame_length  = out_data_ff.frame_length;
endmodule
